// ===== sv/ptpox_pkg.sv =====
// Shared types and constants of the two-point order crossover unit.
`timescale 1ns / 1ps

package ptpox_pkg;

  // Sizes of the permutation stores and fields
  localparam int MAX_GENES   = 64;
  localparam int MIN_CUT_GAP = 3;
  localparam int POS_W       = 6;
  localparam int GENE_W      = 6;
  localparam int LEN_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int MASK_W      = 2 ** GENE_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLOSE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CROSS = 1'b1;

  // Class of a queued item
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_CROSS  = 2'd2
  } kind_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    kind_e                kind;
    logic [POS_W-1:0]     position;
    logic [GENE_W-1:0]    gene_a;
    logic [GENE_W-1:0]    gene_b;
    logic [POS_W-1:0]     lo;
    logic [POS_W-1:0]     hi;
    logic [LEN_W-1:0]     len;
    logic [STATUS_W-1:0]  status;
  } item_t;

endpackage

// ===== sv/ptpox_if.sv =====
// Handshake channels of the two-point order crossover unit.
`timescale 1ns / 1ps

// Request channel: loads and crossover commands
interface ptpox_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [ptpox_pkg::POS_W-1:0]         position;
  logic [ptpox_pkg::GENE_W-1:0]        gene_a;
  logic [ptpox_pkg::GENE_W-1:0]        gene_b;
  logic [ptpox_pkg::POS_W-1:0]         cut_a;
  logic [ptpox_pkg::POS_W-1:0]         cut_b;

  modport source (output valid, req_type, position, gene_a, gene_b, cut_a, cut_b,
                  input ready);
  modport sink (input valid, req_type, position, gene_a, gene_b, cut_a, cut_b,
                output ready);
endinterface

// Result channel: one beat per child position, or one beat for a rejected crossover
interface ptpox_res_if;
  logic                                valid;
  logic                                ready;
  logic [ptpox_pkg::POS_W-1:0]         out_position;
  logic [ptpox_pkg::GENE_W-1:0]        child_a_gene;
  logic [ptpox_pkg::GENE_W-1:0]        child_b_gene;
  logic [ptpox_pkg::STATUS_W-1:0]      status;
  logic                                changed;
  logic                                last;

  modport source (output valid, out_position, child_a_gene, child_b_gene, status,
                  changed, last, input ready);
  modport sink (input valid, out_position, child_a_gene, child_b_gene, status,
                changed, last, output ready);
endinterface

// Configuration write channel
interface ptpox_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ptpox_pkg::LEN_W-1:0]         length_in_use;

  modport source (output valid, length_in_use, input ready);
  modport sink (input valid, length_in_use, output ready);
endinterface

// ===== sv/permutation_two_point_order_crossover_unit.sv =====
// Top level of the two-point order crossover unit: front, queue and back.
// A crossover over L genes first marks the kept ends of each parent, then scans the other
// parent to fill the middle, then gives L results, one per child position.
// A rejected crossover gives a single result; a load gives none.
// Crossovers run one at a time: the back end takes a new item only when idle, and each store has a single read port.
// Reset: asynchronous, active low; length returns to 64, masks and queue clear.
`timescale 1ns / 1ps

module permutation_two_point_order_crossover_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptpox_req_if.sink   req_i,
  ptpox_cfg_if.sink   cfg_i,
  ptpox_res_if.source res_o
);

  logic              push_valid;
  logic              push_ready;
  ptpox_pkg::item_t  push_item;
  logic              pop_valid;
  logic              pop_ready;
  ptpox_pkg::item_t  pop_item;

  // Classify request beats
  ptpox_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decouple front and back
  ptpox_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Execute loads and crossovers
  ptpox_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_o       (res_o)
  );

endmodule

// ===== sv/ptpox_front.sv =====
// Front end: length register, request classification and cut sorting.
`timescale 1ns / 1ps

module ptpox_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ptpox_req_if.sink          req_i,
  ptpox_cfg_if.sink          cfg_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ptpox_pkg::item_t   push_item_o
);

  logic [ptpox_pkg::LEN_W-1:0]  length_q;
  logic [ptpox_pkg::LEN_W-1:0]  length_d;
  logic [ptpox_pkg::LEN_W-1:0]  len_eff;
  logic [ptpox_pkg::POS_W-1:0]  lo;
  logic [ptpox_pkg::POS_W-1:0]  hi;
  logic [ptpox_pkg::POS_W-1:0]  gap;
  logic                         beyond;
  logic                         close;

  // Take a length write on every beat
  assign cfg_i.ready = 1'b1;

  always_comb begin
    length_d = length_q;
    if (cfg_i.valid) begin
      length_d = cfg_i.length_in_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= ptpox_pkg::LEN_W'(ptpox_pkg::MAX_GENES);
    end else begin
      length_q <= length_d;
    end
  end

  // Saturate the length to the store depth
  assign len_eff = (length_q > ptpox_pkg::LEN_W'(ptpox_pkg::MAX_GENES)) ?
                   ptpox_pkg::LEN_W'(ptpox_pkg::MAX_GENES) : length_q;

  // Sort the cuts and check them against the length and the minimum gap
  assign lo     = (req_i.cut_a < req_i.cut_b) ? req_i.cut_a : req_i.cut_b;
  assign hi     = (req_i.cut_a < req_i.cut_b) ? req_i.cut_b : req_i.cut_a;
  assign gap    = hi - lo;
  assign beyond = ({1'b0, hi} >= len_eff);
  assign close  = (gap < ptpox_pkg::POS_W'(ptpox_pkg::MIN_CUT_GAP));

  // Build the queued item
  always_comb begin
    push_item_o.position = req_i.position;
    push_item_o.gene_a   = req_i.gene_a;
    push_item_o.gene_b   = req_i.gene_b;
    push_item_o.lo       = lo;
    push_item_o.hi       = hi;
    push_item_o.len      = len_eff;
    if (req_i.req_type == ptpox_pkg::REQ_LOAD) begin
      push_item_o.kind   = ptpox_pkg::KIND_LOAD;
      push_item_o.status = ptpox_pkg::STATUS_OK;
    end else if (beyond) begin
      push_item_o.kind   = ptpox_pkg::KIND_REJECT;
      push_item_o.status = ptpox_pkg::STATUS_BEYOND;
    end else if (close) begin
      push_item_o.kind   = ptpox_pkg::KIND_REJECT;
      push_item_o.status = ptpox_pkg::STATUS_CLOSE;
    end else begin
      push_item_o.kind   = ptpox_pkg::KIND_CROSS;
      push_item_o.status = ptpox_pkg::STATUS_OK;
    end
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

// ===== sv/ptpox_queue.sv =====
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module ptpox_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  ptpox_pkg::item_t   push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output ptpox_pkg::item_t   pop_item_o
);

  ptpox_pkg::item_t               entry_q [ptpox_pkg::QUEUE_DEPTH];
  logic [ptpox_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ptpox_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ptpox_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                           push;
  logic                           pop;

  assign push_ready_o = (count_q != ptpox_pkg::QCNT_W'(ptpox_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ptpox_pkg::QPTR_W'(ptpox_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ptpox_pkg::QPTR_W'(ptpox_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/ptpox_back.sv =====
// Back end: parent and child stores, taken masks, crossover sequencer, result register.
`timescale 1ns / 1ps

module ptpox_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  ptpox_pkg::item_t   pop_item_i,
  ptpox_res_if.source        res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MARK = 4'b0010,
    ST_FILL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  localparam int PW = ptpox_pkg::POS_W;
  localparam int GW = ptpox_pkg::GENE_W;
  localparam int LW = ptpox_pkg::LEN_W;

  state_e                state_q, state_d;
  logic [LW-1:0]         cnt_q, cnt_d;
  logic [LW-1:0]         len_q, len_d;
  logic [PW-1:0]         lo_q, lo_d;
  logic [PW-1:0]         hi_q, hi_d;
  logic [PW-1:0]         fa_q, fa_d;
  logic [PW-1:0]         fb_q, fb_d;
  logic [ptpox_pkg::MASK_W-1:0] taken_a_q, taken_a_d;
  logic [ptpox_pkg::MASK_W-1:0] taken_b_q, taken_b_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [PW-1:0]         rd_idx_q, rd_idx_d;
  logic                  chg_q, chg_d;
  logic                  out_vld_q, out_vld_d;

  // Stores and their registered read data
  logic [GW-1:0]         pa_mem [ptpox_pkg::MAX_GENES];
  logic [GW-1:0]         pb_mem [ptpox_pkg::MAX_GENES];
  logic [GW-1:0]         ca_mem [ptpox_pkg::MAX_GENES];
  logic [GW-1:0]         cb_mem [ptpox_pkg::MAX_GENES];
  logic [GW-1:0]         pa_rd_q, pb_rd_q, ca_rd_q, cb_rd_q;

  // Result register
  logic [PW-1:0]                    res_pos_q, res_pos_d;
  logic [GW-1:0]                    res_ca_q, res_ca_d;
  logic [GW-1:0]                    res_cb_q, res_cb_d;
  logic [ptpox_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic                             res_chg_q, res_chg_d;
  logic                             res_last_q, res_last_d;

  logic                  take;
  logic                  adv;
  logic                  issue;
  logic                  load_wr;
  logic                  fill_wr_a;
  logic                  fill_wr_b;
  logic                  keep;
  logic                  mid;
  logic [GW-1:0]         emit_ca;
  logic [GW-1:0]         emit_cb;
  logic                  diff;
  logic                  is_last;
  logic                  phase_end;

  // Result slot is free when empty or being drained this cycle
  assign take = !out_vld_q || res_o.ready;
  // Read stage moves on unless a result waits on a full slot
  assign adv   = (state_q != ST_EMIT) || !rd_vld_q || take;
  assign issue = (state_q != ST_IDLE) && (cnt_q < len_q) && adv;

  // Position classes of the entry in the read stage
  assign keep    = (rd_idx_q <= lo_q) || (rd_idx_q >= hi_q);
  assign mid     = (rd_idx_q > lo_q) && (rd_idx_q < hi_q);
  assign emit_ca = (mid && (rd_idx_q < fa_q)) ? ca_rd_q : pa_rd_q;
  assign emit_cb = (mid && (rd_idx_q < fb_q)) ? cb_rd_q : pb_rd_q;
  assign diff    = (emit_ca != pa_rd_q) || (emit_cb != pb_rd_q);
  assign is_last = ({1'b0, rd_idx_q} == (len_q - 1'b1));

  // Fill only genes not taken, until the middle is full
  assign fill_wr_a = (state_q == ST_FILL) && rd_vld_q && !taken_a_q[pb_rd_q] &&
                     (fa_q < hi_q);
  assign fill_wr_b = (state_q == ST_FILL) && rd_vld_q && !taken_b_q[pa_rd_q] &&
                     (fb_q < hi_q);

  assign load_wr   = (state_q == ST_IDLE) && pop_valid_i &&
                     (pop_item_i.kind == ptpox_pkg::KIND_LOAD) &&
                     ({1'b0, pop_item_i.position} < LW'(ptpox_pkg::MAX_GENES));
  assign phase_end = (cnt_q == len_q) && rd_vld_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    fa_d         = fa_q;
    fb_d         = fb_q;
    taken_a_d    = taken_a_q;
    taken_b_d    = taken_b_q;
    rd_vld_d     = rd_vld_q;
    rd_idx_d     = rd_idx_q;
    chg_d        = chg_q;
    out_vld_d    = out_vld_q && !res_o.ready;
    res_pos_d    = res_pos_q;
    res_ca_d     = res_ca_q;
    res_cb_d     = res_cb_q;
    res_status_d = res_status_q;
    res_chg_d    = res_chg_q;
    res_last_d   = res_last_q;
    pop_ready_o  = 1'b0;

    // Advance the read stage
    if (adv && (state_q != ST_IDLE)) begin
      rd_vld_d = issue;
      rd_idx_d = cnt_q[PW-1:0];
      if (issue) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          case (pop_item_i.kind)
            ptpox_pkg::KIND_LOAD: begin
              pop_ready_o = 1'b1;
            end
            ptpox_pkg::KIND_REJECT: begin
              pop_ready_o = take;
              if (take) begin
                out_vld_d    = 1'b1;
                res_pos_d    = '0;
                res_ca_d     = '0;
                res_cb_d     = '0;
                res_status_d = pop_item_i.status;
                res_chg_d    = 1'b0;
                res_last_d   = 1'b1;
              end
            end
            ptpox_pkg::KIND_CROSS: begin
              pop_ready_o = 1'b1;
              len_d       = pop_item_i.len;
              lo_d        = pop_item_i.lo;
              hi_d        = pop_item_i.hi;
              taken_a_d   = '0;
              taken_b_d   = '0;
              cnt_d       = '0;
              rd_vld_d    = 1'b0;
              state_d     = ST_MARK;
            end
            default: begin
              pop_ready_o = 1'b1;
            end
          endcase
        end
      end
      ST_MARK: begin
        // Mark the kept ends of each parent as taken
        if (rd_vld_q && keep) begin
          taken_a_d[pa_rd_q] = 1'b1;
          taken_b_d[pb_rd_q] = 1'b1;
        end
        if (phase_end) begin
          cnt_d    = '0;
          rd_vld_d = 1'b0;
          fa_d     = lo_q + 1'b1;
          fb_d     = lo_q + 1'b1;
          state_d  = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_wr_a) begin
          fa_d = fa_q + 1'b1;
        end
        if (fill_wr_b) begin
          fb_d = fb_q + 1'b1;
        end
        if (phase_end) begin
          cnt_d    = '0;
          rd_vld_d = 1'b0;
          chg_d    = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hand one position to the result register
        if (rd_vld_q && take) begin
          out_vld_d    = 1'b1;
          res_pos_d    = rd_idx_q;
          res_ca_d     = emit_ca;
          res_cb_d     = emit_cb;
          res_status_d = ptpox_pkg::STATUS_OK;
          res_chg_d    = is_last && (chg_q || diff);
          res_last_d   = is_last;
          chg_d        = chg_q || diff;
          if (cnt_q == len_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      len_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      fa_q      <= '0;
      fb_q      <= '0;
      taken_a_q <= '0;
      taken_b_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      chg_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      fa_q      <= fa_d;
      fb_q      <= fb_d;
      taken_a_q <= taken_a_d;
      taken_b_q <= taken_b_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      chg_q     <= chg_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_pos_q    <= res_pos_d;
    res_ca_q     <= res_ca_d;
    res_cb_q     <= res_cb_d;
    res_status_q <= res_status_d;
    res_chg_q    <= res_chg_d;
    res_last_q   <= res_last_d;
  end

  // Parent stores: written by loads, read by the sequencer
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      pa_mem[pop_item_i.position] <= pop_item_i.gene_a;
      pb_mem[pop_item_i.position] <= pop_item_i.gene_b;
    end
    if (issue) begin
      pa_rd_q <= pa_mem[cnt_q[PW-1:0]];
      pb_rd_q <= pb_mem[cnt_q[PW-1:0]];
    end
  end

  // Child stores: middle genes written during the fill scan
  always_ff @(posedge clk_i) begin
    if (fill_wr_a) begin
      ca_mem[fa_q] <= pb_rd_q;
    end
    if (fill_wr_b) begin
      cb_mem[fb_q] <= pa_rd_q;
    end
    if (issue) begin
      ca_rd_q <= ca_mem[cnt_q[PW-1:0]];
      cb_rd_q <= cb_mem[cnt_q[PW-1:0]];
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.out_position = res_pos_q;
  assign res_o.child_a_gene = res_ca_q;
  assign res_o.child_b_gene = res_cb_q;
  assign res_o.status       = res_status_q;
  assign res_o.changed      = res_chg_q;
  assign res_o.last         = res_last_q;

endmodule

// ===== dv/permutation_two_point_order_crossover_unit_tb.sv =====
// Self-checking testbench of the two-point order crossover unit: directed and random requests.
`timescale 1ns / 1ps

module permutation_two_point_order_crossover_unit_tb;
  import ptpox_pkg::*;

  localparam int LONG_STALL = 1500;
  localparam int PRINT_CAP  = 40;

  typedef logic [MAX_GENES-1:0][GENE_W-1:0] chrom_t;

  typedef struct packed {
    logic              req_type;
    logic [POS_W-1:0]  position;
    logic [GENE_W-1:0] gene_a;
    logic [GENE_W-1:0] gene_b;
    logic [POS_W-1:0]  cut_a;
    logic [POS_W-1:0]  cut_b;
  } request_t;

  typedef struct packed {
    logic [POS_W-1:0]    out_position;
    logic [GENE_W-1:0]   child_a_gene;
    logic [GENE_W-1:0]   child_b_gene;
    logic [STATUS_W-1:0] status;
    logic                changed;
    logic                last;
  } child_beat_t;

  logic clk_i;
  logic rst_ni;

  ptpox_req_if req_if();
  ptpox_res_if res_if();
  ptpox_cfg_if cfg_if();

  permutation_two_point_order_crossover_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // Predictor state: parent genes as seen by accepted loads, and the length register
  chrom_t           parent_a_genes;
  chrom_t           parent_b_genes;
  logic [LEN_W-1:0] length_setting = LEN_W'(MAX_GENES);
  child_beat_t      expected_children[$];

  // Stimulus side: pending requests and a mirror of what they will load
  request_t pending_requests[$];
  chrom_t   plan_a;
  chrom_t   plan_b;
  request_t next_request;
  request_t seen_request;
  child_beat_t want;

  int  requests_queued = 0;
  int  requests_taken  = 0;
  int  loads_taken     = 0;
  int  crossovers_taken = 0;
  int  rejects_taken   = 0;
  int  beats_seen      = 0;
  int  error_count     = 0;
  int  send_gap        = 0;
  int  recv_wait       = 0;
  int  hold_left       = 0;
  bit  req_beat        = 1'b0;
  bit  res_beat        = 1'b0;
  bit  steady_phase    = 1'b0;
  bit  stall_request   = 1'b0;
  bit  long_stall_done = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hang
  initial begin
    #(20_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want_v);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] child beat %0d: %s got %0d, want %0d", $time, beats_seen, what, got,
               want_v);
    end
  endtask

  // Fill the middle of one child from the donor parent, skipping genes kept at the ends
  function automatic chrom_t order_fill(chrom_t own, chrom_t donor, int n, int lo, int hi);
    chrom_t           kid;
    logic [MASK_W-1:0] kept;
    int               slot;
    kid  = own;
    kept = '0;
    for (int i = 0; i < n; i++) begin
      if (i <= lo || i >= hi) kept[own[i]] = 1'b1;
    end
    slot = lo + 1;
    for (int j = 0; j < n && slot < hi; j++) begin
      if (!kept[donor[j]]) begin
        kid[slot] = donor[j];
        slot++;
      end
    end
    return kid;
  endfunction

  // Apply one accepted request to the predictor and queue the child beats it causes
  function automatic void predict_request(request_t r);
    int          lo;
    int          hi;
    int          n;
    chrom_t      kid_a;
    chrom_t      kid_b;
    bit          moved;
    child_beat_t beat;
    if (r.req_type == REQ_LOAD) begin
      parent_a_genes[r.position] = r.gene_a;
      parent_b_genes[r.position] = r.gene_b;
      loads_taken++;
      return;
    end
    crossovers_taken++;
    lo = (r.cut_a < r.cut_b) ? r.cut_a : r.cut_b;
    hi = (r.cut_a < r.cut_b) ? r.cut_b : r.cut_a;
    n  = (length_setting > MAX_GENES) ? MAX_GENES : length_setting;
    beat = '0;
    // Reject: beyond the length wins over too close
    if (hi >= n || hi - lo < MIN_CUT_GAP) begin
      beat.status = (hi >= n) ? STATUS_BEYOND : STATUS_CLOSE;
      beat.last   = 1'b1;
      expected_children.push_back(beat);
      rejects_taken++;
      return;
    end
    kid_a = order_fill(parent_a_genes, parent_b_genes, n, lo, hi);
    kid_b = order_fill(parent_b_genes, parent_a_genes, n, lo, hi);
    moved = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (kid_a[i] != parent_a_genes[i] || kid_b[i] != parent_b_genes[i]) moved = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      beat.out_position = POS_W'(i);
      beat.child_a_gene = kid_a[i];
      beat.child_b_gene = kid_b[i];
      beat.status       = STATUS_OK;
      beat.last         = (i == n - 1);
      beat.changed      = (i == n - 1) && moved;
      expected_children.push_back(beat);
    end
  endfunction

  // Sample both handshakes at the rising edge; predict on requests, check on results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_beat = req_if.valid && req_if.ready;
      res_beat = res_if.valid && res_if.ready;
      if (req_beat) begin
        seen_request.req_type = req_if.req_type;
        seen_request.position = req_if.position;
        seen_request.gene_a   = req_if.gene_a;
        seen_request.gene_b   = req_if.gene_b;
        seen_request.cut_a    = req_if.cut_a;
        seen_request.cut_b    = req_if.cut_b;
        predict_request(seen_request);
        requests_taken++;
      end
      if (res_beat) begin
        beats_seen++;
        if (expected_children.size() == 0) begin
          flag_mismatch("beat with nothing outstanding, position", res_if.out_position, -1);
        end else begin
          want = expected_children.pop_front();
          if (res_if.out_position != want.out_position)
            flag_mismatch("out_position", res_if.out_position, want.out_position);
          if (res_if.child_a_gene != want.child_a_gene)
            flag_mismatch("child_a_gene", res_if.child_a_gene, want.child_a_gene);
          if (res_if.child_b_gene != want.child_b_gene)
            flag_mismatch("child_b_gene", res_if.child_b_gene, want.child_b_gene);
          if (res_if.status != want.status)
            flag_mismatch("status", res_if.status, want.status);
          if (res_if.changed !== want.changed)
            flag_mismatch("changed", res_if.changed, want.changed);
          if (res_if.last !== want.last)
            flag_mismatch("last", res_if.last, want.last);
        end
      end
    end
  end

  // Request driver: hold a beat until taken, then wait the drawn gap before the next
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_beat) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_request = pending_requests.pop_front();
          req_if.req_type <= next_request.req_type;
          req_if.position <= next_request.position;
          req_if.gene_a   <= next_request.gene_a;
          req_if.gene_b   <= next_request.gene_b;
          req_if.cut_a    <= next_request.cut_a;
          req_if.cut_b    <= next_request.cut_b;
          req_if.valid    <= 1'b1;
          send_gap = steady_phase ? 0 : $urandom_range(0, 6);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stall per beat, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_request && !long_stall_done) begin
        hold_left       = LONG_STALL;
        long_stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (res_beat || !res_if.ready) begin
        if (res_beat) recv_wait = steady_phase ? 0 : $urandom_range(0, 6);
        if (recv_wait > 0) begin
          recv_wait--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic queue_load(input int pos, input int ga, input int gb);
    request_t r;
    r.req_type = REQ_LOAD;
    r.position = POS_W'(pos);
    r.gene_a   = GENE_W'(ga);
    r.gene_b   = GENE_W'(gb);
    r.cut_a    = POS_W'($urandom);
    r.cut_b    = POS_W'($urandom);
    plan_a[pos] = r.gene_a;
    plan_b[pos] = r.gene_b;
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  task automatic queue_cross(input int ca, input int cb);
    request_t r;
    r.req_type = REQ_CROSS;
    r.position = POS_W'($urandom);
    r.gene_a   = GENE_W'($urandom);
    r.gene_b   = GENE_W'($urandom);
    r.cut_a    = POS_W'(ca);
    r.cut_b    = POS_W'(cb);
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  // Drain: every request taken and every child beat seen, then let the back end settle
  task automatic wait_idle();
    while (requests_taken != requests_queued || expected_children.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    @(negedge clk_i);
    cfg_if.length_in_use <= value;
    cfg_if.valid         <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    length_setting = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic chrom_t shuffled_genes();
    chrom_t            p;
    int                j;
    logic [GENE_W-1:0] tmp;
    for (int i = 0; i < MAX_GENES; i++) p[i] = GENE_W'(i);
    for (int i = MAX_GENES - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = p[i];
      p[i] = p[j];
      p[j] = tmp;
    end
    return p;
  endfunction

  task automatic queue_fresh_parents(input int n);
    chrom_t a;
    chrom_t b;
    a = shuffled_genes();
    b = shuffled_genes();
    for (int i = 0; i < n; i++) queue_load(i, a[i], b[i]);
  endtask

  // One random phase: set the length, load fresh permutations, then mostly
  // swaps followed by a crossover with legal cuts, plus stray cuts and stray loads
  task automatic run_phase(input int setting, input int extra, input bit steady,
                           input bit hold);
    int n;
    int pushed;
    int swaps;
    int p;
    int q;
    int lo;
    int hi;
    int ap;
    int bp;
    int aq;
    int bq;
    wait_idle();
    steady_phase = steady;
    write_length(LEN_W'(setting));
    n = (setting > MAX_GENES) ? MAX_GENES : setting;
    queue_fresh_parents(n);
    pushed = 0;
    while (pushed < extra) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          swaps = $urandom_range(0, 3);
          repeat (swaps) begin
            p  = $urandom_range(0, n - 1);
            q  = $urandom_range(0, n - 1);
            ap = plan_a[p];
            bp = plan_b[p];
            aq = plan_a[q];
            bq = plan_b[q];
            queue_load(p, aq, bq);
            queue_load(q, ap, bp);
          end
          lo = $urandom_range(0, n - 4);
          hi = $urandom_range(lo + 3, n - 1);
          if ($urandom_range(0, 1)) queue_cross(lo, hi);
          else queue_cross(hi, lo);
          pushed += 2 * swaps + 1;
        end
        7, 8: begin
          queue_cross($urandom_range(0, 63), $urandom_range(0, 63));
          pushed++;
        end
        default: begin
          queue_load($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
          pushed++;
        end
      endcase
    end
    // Hold off results while the sender keeps pushing, so the unit backs up
    if (hold) stall_request = 1'b1;
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_LOAD;
    req_if.position      = '0;
    req_if.gene_a        = '0;
    req_if.gene_b        = '0;
    req_if.cut_a         = '0;
    req_if.cut_b         = '0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.length_in_use = '0;
    rst_ni               = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Rejects before any gene is loaded: too close, swapped, gap one short of the minimum
    queue_cross(7, 7);
    queue_cross(20, 18);
    queue_cross(0, 2);

    // Shortest length with extreme genes, both cut orders, and every reject kind
    wait_idle();
    write_length(LEN_W'(4));
    queue_load(0, 0, 9);
    queue_load(1, 63, 5);
    queue_load(2, 5, 63);
    queue_load(3, 9, 0);
    queue_cross(0, 3);
    queue_cross(3, 0);
    queue_cross(0, 2);
    queue_cross(1, 4);
    queue_cross(63, 63);
    queue_cross(0, 63);
    queue_load(63, 63, 63);

    // Scan runs dry: every donor gene already kept, so children equal parents
    for (int i = 0; i < 4; i++) queue_load(i, 1, 1);
    queue_cross(0, 3);

    // Donor not a permutation: the same gene lands twice in the middle
    for (int i = 0; i < 4; i++) queue_load(i, i, 4);
    queue_cross(3, 0);

    run_phase(64, 25, 1'b1, 1'b1);
    run_phase(127, 25, 1'b1, 1'b0);
    run_phase(4, 25, 1'b0, 1'b0);
    run_phase($urandom_range(5, 63), 25, 1'b0, 1'b0);
    run_phase(5, 25, 1'b0, 1'b0);
    run_phase($urandom_range(5, 63), 25, 1'b0, 1'b0);
    run_phase(64, 25, 1'b0, 1'b0);

    wait_idle();
    if (expected_children.size() != 0)
      flag_mismatch("child beats never seen", 0, expected_children.size());
    $display("Run covered %0d requests: %0d loads and %0d crossovers, %0d of them rejected.",
             requests_taken, loads_taken, crossovers_taken, rejects_taken);
    $display("Checked %0d child beats over lengths 4 to 64, a saturated length, a long stall.",
             beats_seen);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
